FILE: hdl/cau_pkg.sv
// package of the complex arithmetic unit: constants, opcodes, status codes, atan table
package cau_pkg;

  // fixed point format and iteration counts
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned DIV_STEPS     = 33;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned ITER_STEPS    =
      (CORDIC_STAGES > DIV_STEPS) ? CORDIC_STAGES : DIV_STEPS;
  localparam int unsigned NUM_STAGES    = ITER_STEPS + 5;

  // derived shifts
  localparam int unsigned DIV_SH = 32 - FRAC_BITS;
  localparam int unsigned ANG_SH = 30 - FRAC_BITS;

  // cordic datapath widths
  localparam int unsigned CX_W = 44;
  localparam int unsigned Z_W  = 35;

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

  // opcodes
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_NEG   = 3'd5,
    OP_MAG   = 3'd6,
    OP_ANGLE = 3'd7
  } op_e;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // atan(2^-i) in Q2.30
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 35'sd843314857;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043837;
      3:  v = 35'sd133525159;
      4:  v = 35'sd67021687;
      5:  v = 35'sd33543516;
      6:  v = 35'sd16775851;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194283;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048576;
      11: v = 35'sd524288;
      12: v = 35'sd262144;
      13: v = 35'sd131072;
      14: v = 35'sd65536;
      15: v = 35'sd32768;
      16: v = 35'sd16384;
      17: v = 35'sd8192;
      18: v = 35'sd4096;
      19: v = 35'sd2048;
      20: v = 35'sd1024;
      21: v = 35'sd512;
      22: v = 35'sd256;
      23: v = 35'sd128;
      24: v = 35'sd64;
      25: v = 35'sd32;
      26: v = 35'sd16;
      27: v = 35'sd8;
      28: v = 35'sd4;
      29: v = 35'sd2;
      30: v = 35'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/complex_arithmetic_unit.sv
// complex arithmetic unit: pipelined add, sub, mul, div, conj, negate, magnitude and angle
//
// One item enters per cycle while in_stall_o is low, and its result leaves after passing NUM_STAGES register stages.
// The depth is set by the restoring divider, which retires one of 33 quotient bits
// per stage; the square root (32 stages) and the CORDIC vectoring chain
// (CORDIC_STAGES stages) run in the same stages alongside it. A stage holding no
// item fills while later stages are stalled, so a waiting result does not block
// new items until the pipeline is full. Operands and results are signed Q16.16;
// magnitude and angle land in res_re with res_im zero. Status gives divide by
// zero (result 0) or saturation of any part.
module complex_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic [1:0]         status_o
);
  import cau_pkg::*;

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [Z_W:0] ANG_HALF =
      (ANG_SH > 0) ? ((Z_W + 1)'(1) <<< (ANG_SH - 1)) : '0;

  typedef struct packed {
    op_e               op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } s0_t;

  typedef struct packed {
    op_e                op;
    logic               divz;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] p5;
    logic [31:0]        fre;
    logic [31:0]        fim;
    logic               fsat;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [4:0]         msb;
    logic               azero;
    logic               xneg;
    logic               yneg;
  } s1_t;

  typedef struct packed {
    op_e                   op;
    logic                  divz;
    logic [31:0]           fre;
    logic [31:0]           fim;
    logic                  fsat;
    logic signed [64:0]    sre;
    logic signed [64:0]    sim;
    logic [63:0]           den;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    logic                  azero;
  } s2_t;

  typedef struct packed {
    op_e                    op;
    logic                   divz;
    logic [31:0]            fre;
    logic [31:0]            fim;
    logic                   fsat;
    logic                   nre;
    logic                   nim;
    logic                   dsre;
    logic                   dsim;
    logic [63:0]            rre;
    logic [63:0]            rim;
    logic [DIV_STEPS-1:0]   xre;
    logic [DIV_STEPS-1:0]   xim;
    logic [DIV_STEPS-1:0]   qre;
    logic [DIV_STEPS-1:0]   qim;
    logic [63:0]            den;
    logic [63:0]            sq_s;
    logic [63:0]            sq_r;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    logic                   azero;
  } iter_t;

  // saturate a 33 bit sum to 32 bits
  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // sign and magnitude to 32 bits, overflow flag
  function automatic logic satmag_ovf(input logic neg, input logic [63:0] mag);
    return neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
  endfunction

  function automatic logic [31:0] satmag_val(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (satmag_ovf(neg, mag)) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg) begin
      r = 32'd0 - mag[31:0];
    end else begin
      r = mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs65(input logic signed [64:0] v);
    logic [64:0] t;
    t = v[64] ? (65'd0 - 65'(v)) : 65'(v);
    return t[63:0];
  endfunction

  // set up divider, root and cordic state; finish multiply
  function automatic iter_t iter_init(input s2_t c);
    iter_t       n;
    logic [63:0] mre;
    logic [63:0] mim;
    logic [63:0] rnd_re;
    logic [63:0] rnd_im;
    mre    = abs65(c.sre);
    mim    = abs65(c.sim);
    rnd_re = (mre + HALF) >> FRAC_BITS;
    rnd_im = (mim + HALF) >> FRAC_BITS;
    n.op    = c.op;
    n.divz  = c.divz;
    n.fre   = c.fre;
    n.fim   = c.fim;
    n.fsat  = c.fsat;
    if (c.op == OP_MUL) begin
      n.fre  = satmag_val(c.sre[64], rnd_re);
      n.fim  = satmag_val(c.sim[64], rnd_im);
      n.fsat = satmag_ovf(c.sre[64], rnd_re) | satmag_ovf(c.sim[64], rnd_im);
    end
    n.nre   = c.sre[64];
    n.nim   = c.sim[64];
    n.dsre  = (mre >> DIV_SH) >= c.den;
    n.dsim  = (mim >> DIV_SH) >= c.den;
    n.rre   = mre >> DIV_SH;
    n.rim   = mim >> DIV_SH;
    n.xre   = DIV_STEPS'(mre << (FRAC_BITS + 1));
    n.xim   = DIV_STEPS'(mim << (FRAC_BITS + 1));
    n.qre   = '0;
    n.qim   = '0;
    n.den   = c.den;
    n.sq_s  = c.den;
    n.sq_r  = '0;
    n.cx    = c.cx;
    n.cy    = c.cy;
    n.z     = c.z;
    n.azero = c.azero;
    return n;
  endfunction

  // one divider bit, plus one root step and one cordic rotation while their step counts last
  function automatic iter_t iter_step(input iter_t c, input int unsigned j);
    iter_t                  n;
    logic [64:0]            tr;
    logic [64:0]            ti;
    logic [63:0]            bitv;
    logic [63:0]            tq;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    n  = c;
    cx = c.cx;
    cy = c.cy;
    z  = c.z;
    // restoring division, real and imaginary parts share the divisor
    if (j < DIV_STEPS) begin
      tr = {c.rre, c.xre[DIV_STEPS-1]};
      ti = {c.rim, c.xim[DIV_STEPS-1]};
      n.xre = c.xre << 1;
      n.xim = c.xim << 1;
      if (tr >= {1'b0, c.den}) begin
        n.rre = 64'(tr - {1'b0, c.den});
        n.qre = {c.qre[DIV_STEPS-2:0], 1'b1};
      end else begin
        n.rre = tr[63:0];
        n.qre = {c.qre[DIV_STEPS-2:0], 1'b0};
      end
      if (ti >= {1'b0, c.den}) begin
        n.rim = 64'(ti - {1'b0, c.den});
        n.qim = {c.qim[DIV_STEPS-2:0], 1'b1};
      end else begin
        n.rim = ti[63:0];
        n.qim = {c.qim[DIV_STEPS-2:0], 1'b0};
      end
    end
    // digit by digit square root
    if (j < SQRT_STEPS) begin
      bitv = 64'd1 << (62 - 2 * j);
      tq   = c.sq_r + bitv;
      if (c.sq_s >= tq) begin
        n.sq_s = c.sq_s - tq;
        n.sq_r = (c.sq_r >> 1) + bitv;
      end else begin
        n.sq_r = c.sq_r >> 1;
      end
    end
    // cordic vectoring
    if (j < CORDIC_STAGES) begin
      if (cy < 0) begin
        n.cx = cx - (cy >>> j);
        n.cy = cy + (cx >>> j);
        n.z  = z - atan_q30(j);
      end else begin
        n.cx = cx + (cy >>> j);
        n.cy = cy - (cx >>> j);
        n.z  = z + atan_q30(j);
      end
    end
    return n;
  endfunction

  logic [NUM_STAGES-1:0] vld_d, vld_q, adv;
  s0_t   s0_q;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  iter_t iter_d [ITER_STEPS+1];
  iter_t iter_q [ITER_STEPS+1];
  logic signed [31:0] res_re_d, res_re_q, res_im_d, res_im_q;
  logic [1:0]         status_d, status_q;

  // stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: products, simple ops, operand magnitudes for the angle
  always_comb begin
    logic signed [32:0] t_re;
    logic signed [32:0] t_im;
    logic signed [31:0] m4;
    logic signed [31:0] m5;
    logic [31:0]        mx;
    t_re = '0;
    t_im = '0;
    case (s0_q.op)
      OP_ADD: begin
        t_re = 33'(s0_q.ar) + 33'(s0_q.br);
        t_im = 33'(s0_q.ai) + 33'(s0_q.bi);
      end
      OP_SUB: begin
        t_re = 33'(s0_q.ar) - 33'(s0_q.br);
        t_im = 33'(s0_q.ai) - 33'(s0_q.bi);
      end
      OP_CONJ: begin
        t_re = 33'(s0_q.ar);
        t_im = 33'sd0 - 33'(s0_q.ai);
      end
      OP_NEG: begin
        t_re = 33'sd0 - 33'(s0_q.ar);
        t_im = 33'sd0 - 33'(s0_q.ai);
      end
      default: begin
        t_re = '0;
        t_im = '0;
      end
    endcase
    m4 = (s0_q.op == OP_MAG) ? s0_q.ar : s0_q.br;
    m5 = (s0_q.op == OP_MAG) ? s0_q.ai : s0_q.bi;
    s1_d.op   = s0_q.op;
    s1_d.divz = (s0_q.br == 32'sd0) && (s0_q.bi == 32'sd0);
    s1_d.p0   = s0_q.ar * s0_q.br;
    s1_d.p1   = s0_q.ai * s0_q.bi;
    s1_d.p2   = s0_q.ar * s0_q.bi;
    s1_d.p3   = s0_q.ai * s0_q.br;
    s1_d.p4   = m4 * m4;
    s1_d.p5   = m5 * m5;
    s1_d.fre  = sat33(t_re);
    s1_d.fim  = sat33(t_im);
    s1_d.fsat = (t_re[32] != t_re[31]) || (t_im[32] != t_im[31]);
    s1_d.ax   = s0_q.ar[31] ? (32'd0 - 32'(s0_q.ar)) : 32'(s0_q.ar);
    s1_d.ay   = s0_q.ai[31] ? (32'd0 - 32'(s0_q.ai)) : 32'(s0_q.ai);
    mx        = (s1_d.ax > s1_d.ay) ? s1_d.ax : s1_d.ay;
    s1_d.msb  = '0;
    for (int i = 0; i < 32; i++) begin
      if (mx[i]) begin
        s1_d.msb = 5'(i);
      end
    end
    s1_d.azero = (mx == 32'd0);
    s1_d.xneg  = s0_q.ar[31];
    s1_d.yneg  = s0_q.ai[31];
  end

  // stage 2: product sums, divisor, cordic normalisation and quadrant fold
  always_comb begin
    logic [5:0]             sh;
    logic signed [CX_W-1:0] cy;
    s2_d.op   = s1_q.op;
    s2_d.divz = s1_q.divz;
    s2_d.fre  = s1_q.fre;
    s2_d.fim  = s1_q.fim;
    s2_d.fsat = s1_q.fsat;
    case (s1_q.op)
      OP_MUL: begin
        s2_d.sre = 65'(s1_q.p0) - 65'(s1_q.p1);
        s2_d.sim = 65'(s1_q.p2) + 65'(s1_q.p3);
      end
      OP_DIV: begin
        s2_d.sre = 65'(s1_q.p0) + 65'(s1_q.p1);
        s2_d.sim = 65'(s1_q.p3) - 65'(s1_q.p2);
      end
      default: begin
        s2_d.sre = '0;
        s2_d.sim = '0;
      end
    endcase
    s2_d.den = $unsigned(s1_q.p4) + $unsigned(s1_q.p5);
    sh       = 6'd40 - {1'b0, s1_q.msb};
    s2_d.cx  = $signed(CX_W'(s1_q.ax) << sh);
    cy       = $signed(CX_W'(s1_q.ay) << sh);
    if (s1_q.yneg) begin
      cy = -cy;
    end
    s2_d.z = '0;
    if (s1_q.xneg) begin
      s2_d.z = s1_q.yneg ? -PI_Q30 : PI_Q30;
      cy     = -cy;
    end
    s2_d.cy    = cy;
    s2_d.azero = s1_q.azero;
  end

  // stages 3 onwards: iteration chain
  always_comb begin
    iter_d[0] = iter_init(s2_q);
    for (int unsigned k = 1; k <= ITER_STEPS; k++) begin
      iter_d[k] = iter_step(iter_q[k-1], k - 1);
    end
  end

  // last stage: rounding, saturation and result select
  always_comb begin
    iter_t              c;
    logic [DIV_STEPS:0] qr;
    logic [DIV_STEPS:0] qi;
    logic [63:0]        rt;
    logic signed [Z_W:0] za;
    logic               sat;
    c   = iter_q[ITER_STEPS];
    qr  = ({1'b0, c.qre} + 1'b1) >> 1;
    qi  = ({1'b0, c.qim} + 1'b1) >> 1;
    rt  = c.sq_r + ((c.sq_s > c.sq_r) ? 64'd1 : 64'd0);
    za  = ((Z_W + 1)'(c.z) + ANG_HALF) >>> ANG_SH;
    res_re_d = '0;
    res_im_d = '0;
    sat      = 1'b0;
    case (c.op)
      OP_DIV: begin
        if (c.dsre) begin
          res_re_d = c.nre ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          res_re_d = satmag_val(c.nre, 64'(qr));
        end
        if (c.dsim) begin
          res_im_d = c.nim ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          res_im_d = satmag_val(c.nim, 64'(qi));
        end
        sat = c.dsre || c.dsim || (!c.dsre && satmag_ovf(c.nre, 64'(qr))) ||
              (!c.dsim && satmag_ovf(c.nim, 64'(qi)));
      end
      OP_MAG: begin
        res_re_d = satmag_val(1'b0, rt);
        sat      = satmag_ovf(1'b0, rt);
      end
      OP_ANGLE: begin
        if (c.azero) begin
          res_re_d = '0;
        end else if (za > (Z_W + 1)'(64'sh7FFF_FFFF)) begin
          res_re_d = 32'sh7FFF_FFFF;
          sat      = 1'b1;
        end else if (za < -(Z_W + 1)'(64'sh8000_0000)) begin
          res_re_d = 32'sh8000_0000;
          sat      = 1'b1;
        end else begin
          res_re_d = za[31:0];
        end
      end
      default: begin
        res_re_d = c.fre;
        res_im_d = c.fim;
        sat      = c.fsat;
      end
    endcase
    if (c.op == OP_DIV && c.divz) begin
      res_re_d = '0;
      res_im_d = '0;
      status_d = ST_DIVZ;
    end else if (sat) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  // payload registers, loaded as their stage advances
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_q.op <= op_e'(req_type_i);
      s0_q.ar <= a_re_i;
      s0_q.ai <= a_im_i;
      s0_q.br <= b_re_i;
      s0_q.bi <= b_im_i;
    end
    if (adv[1]) begin
      s1_q <= s1_d;
    end
    if (adv[2]) begin
      s2_q <= s2_d;
    end
    for (int k = 0; k <= ITER_STEPS; k++) begin
      if (adv[3+k]) begin
        iter_q[k] <= iter_d[k];
      end
    end
    if (adv[NUM_STAGES-1]) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
    end
  end

  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = status_q;

endmodule

FILE: verif/tb.sv
// testbench of the complex arithmetic unit: directed table, then random items against a predictor
`timescale 1ns / 100ps

module tb;
  import cau_pkg::*;

  localparam int N_RANDOM   = 1330;
  localparam int HOLD_LEN   = 300;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYC  = 60;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         st;
  } cres_t;

  typedef struct {
    op_e                op;
    logic signed [31:0] ar, ai, br, bi;
    bit                 typed;
    cres_t              res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i = OP_ADD;
  logic signed [31:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] res_re_o, res_im_o;
  logic [1:0]         status_o;

  cres_t  result_q[$];
  bit     cur_typed = 1'b0;
  cres_t  cur_res = '0;
  int     n_fail = 0, n_in = 0, n_out = 0, op_count[8];
  int     n_sat = 0, n_divz = 0;
  bit     hold_req = 1'b0, done = 1'b0;
  int     idle_cyc = 0;

  complex_arithmetic_unit dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] mag64(longint p);
    return (p < 0) ? 64'(-p) : 64'(p);
  endfunction

  // sign and magnitude of p1 + p2
  function automatic bit signed_sum(longint p1, longint p2, output logic [63:0] m);
    logic [63:0] m1 = mag64(p1), m2 = mag64(p2);
    bit n1 = p1 < 0, n2 = p2 < 0;
    if (n1 == n2) begin
      m = m1 + m2;
      return n1 && (m != 0);
    end
    if (m1 >= m2) begin
      m = m1 - m2;
      return n1 && (m != 0);
    end
    m = m2 - m1;
    return n2;
  endfunction

  function automatic logic [31:0] clip_mag(bit neg, logic [63:0] m, inout bit sat);
    if (!neg) begin
      if (m > 64'h7fffffff) begin
        sat = 1'b1;
        m = 64'h7fffffff;
      end
      return m[31:0];
    end
    if (m > 64'h80000000) begin
      sat = 1'b1;
      m = 64'h80000000;
    end
    return 32'(64'd0 - m);
  endfunction

  function automatic logic [31:0] clip_val(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      v = -64'sd2147483648;
    end
    return v[31:0];
  endfunction

  // long division with FRAC_BITS fraction bits, round half away from zero
  function automatic logic [31:0] frac_quot(bit neg, logic [63:0] num, logic [63:0] den,
                                            inout bit sat);
    logic [63:0] q = num / den, r = num % den;
    if (q >= (64'd1 << DIV_SH)) begin
      sat = 1'b1;
      return neg ? 32'h80000000 : 32'h7fffffff;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= den) q = q + 1;
    return clip_mag(neg, q, sat);
  endfunction

  function automatic logic [63:0] root_rnd(logic [63:0] s);
    logic [63:0] r = 0, b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r;
  endfunction

  // cordic vectoring atan2 on a Q2.30 accumulator
  function automatic logic [31:0] phase_of(longint x, longint y, inout bit sat);
    logic [63:0] ax = mag64(x), ay = mag64(y), m;
    int     sh = 0;
    longint cx, cy, z = 0, t;
    m = (ax > ay) ? ax : ay;
    if (m == 0) return '0;
    while ((m << 1) < (64'd1 << 41)) begin
      m = m << 1;
      sh++;
    end
    cx = longint'(ax << sh);
    cy = longint'(ay << sh);
    if (y < 0) cy = -cy;
    if (x < 0) begin
      z = (y < 0) ? -longint'(PI_Q30) : longint'(PI_Q30);
      cy = -cy;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (cy < 0) begin
        t  = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z  = z - longint'(atan_q30(i));
      end else begin
        t  = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z  = z + longint'(atan_q30(i));
      end
      cx = t;
    end
    if (FRAC_BITS < 30) z = (z + (64'sd1 << (ANG_SH - 1))) >>> ANG_SH;
    return clip_val(z, sat);
  endfunction

  function automatic cres_t complex_op(op_e op, logic signed [31:0] a_r, a_i, b_r, b_i);
    longint ar = a_r, ai = a_i, br = b_r, bi = b_i;
    logic [63:0] m, den;
    bit sat = 1'b0, neg;
    cres_t r = '0;
    r.st = ST_OK;
    case (op)
      OP_ADD: begin
        r.re = clip_val(ar + br, sat);
        r.im = clip_val(ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clip_val(ar - br, sat);
        r.im = clip_val(ai - bi, sat);
      end
      OP_MUL: begin
        neg  = signed_sum(ar * br, -(ai * bi), m);
        r.re = clip_mag(neg, (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS, sat);
        neg  = signed_sum(ar * bi, ai * br, m);
        r.im = clip_mag(neg, (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS, sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.st = ST_DIVZ;
        end else begin
          den  = 64'(br * br) + 64'(bi * bi);
          neg  = signed_sum(ar * br, ai * bi, m);
          r.re = frac_quot(neg, m, den, sat);
          neg  = signed_sum(ai * br, -(ar * bi), m);
          r.im = frac_quot(neg, m, den, sat);
        end
      end
      OP_CONJ: begin
        r.re = clip_val(ar, sat);
        r.im = clip_val(-ai, sat);
      end
      OP_NEG: begin
        r.re = clip_val(-ar, sat);
        r.im = clip_val(-ai, sat);
      end
      OP_MAG: r.re = clip_mag(1'b0, root_rnd(64'(ar * ar) + 64'(ai * ai)), sat);
      default: r.re = phase_of(ar, ai, sat);
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    n_fail++;
  endtask

  // accepted items and results, sampled at the rising edge
  always @(posedge clk_i) begin
    cres_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        e = cur_typed ? cur_res : complex_op(op_e'(req_type_i), a_re_i, a_im_i, b_re_i, b_im_i);
        result_q.push_back(e);
        op_count[req_type_i]++;
        n_in++;
        if (e.st == ST_SAT) n_sat++;
        if (e.st == ST_DIVZ) n_divz++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (result_q.size() == 0) begin
          $display("[%0t] result with no item outstanding", $realtime);
          n_fail++;
        end else begin
          e = result_q.pop_front();
          if (res_re_o !== e.re) report_mismatch("res_re", res_re_o, e.re);
          if (res_im_o !== e.im) report_mismatch("res_im", res_im_o, e.im);
          if (status_o !== e.st) report_mismatch("status", status_o, e.st);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!done && idle_cyc >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stall: random runs, one long hold-off per request
  always @(negedge clk_i) begin
    static int run = 0;
    static bit stl = 1'b0;
    static int hold = 0;
    if (hold_req && hold == 0 && !stl) begin
      hold = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold > 0) begin
      hold--;
      out_stall_i = 1'b1;
    end else begin
      if (run == 0) begin
        stl = ($urandom_range(0, 2) == 0);
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
        if (n_in < 60) stl = 1'b0;
      end
      run--;
      out_stall_i = stl;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(op_e op, logic signed [31:0] ar, ai, br, bi,
                           bit typed, cres_t res);
    req_type_i = op;
    a_re_i = ar;
    a_im_i = ai;
    b_re_i = br;
    b_im_i = bi;
    cur_typed = typed;
    cur_res = res;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic input_gap(int n);
    if (n > 0) begin
      in_valid_i = 1'b0;
      req_type_i = 3'($urandom);
      a_re_i = $urandom;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return MAXV;
      1:       return MINV;
      2:       return '0;
      3, 4:    return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      5, 6:    return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return $urandom;
    endcase
  endfunction

  row_t dir_tbl[$];

  initial begin
    row_t  rw;
    op_e   op;
    logic signed [31:0] ar, ai, br, bi;
    int    k;

    // directed table: typed rows carry a hand-made expected result for simple cases, extremes and error codes
    dir_tbl = '{
      '{OP_ADD, MAXV, MAXV, MAXV, MAXV, 1, '{MAXV, MAXV, ST_SAT}},
      '{OP_SUB, MINV, MINV, 1, 1, 1, '{MINV, MINV, ST_SAT}},
      '{OP_ADD, 32'sd5, -32'sd7, 32'sd1, 32'sd2, 1, '{32'sd6, -32'sd5, ST_OK}},
      '{OP_MUL, 32'sh10000, 0, 32'sh20000, 32'sh30000, 1, '{32'sh20000, 32'sh30000, ST_OK}},
      '{OP_MUL, MINV, MINV, MINV, MINV, 0, '0},
      '{OP_MUL, 32'sd1, 32'sd1, 32'sh8000, 32'sd0, 0, '0},
      '{OP_DIV, 32'sh10000, 32'sh10000, 0, 0, 1, '{0, 0, ST_DIVZ}},
      '{OP_DIV, MAXV, MINV, 0, 0, 1, '{0, 0, ST_DIVZ}},
      '{OP_DIV, MAXV, MAXV, 32'sd1, 32'sd0, 0, '0},
      '{OP_DIV, 32'sh30000, 32'sh10000, 32'sh10000, -32'sh20000, 0, '0},
      '{OP_DIV, 32'sd1, 32'sd0, 32'sd3, 32'sd0, 0, '0},
      '{OP_CONJ, MINV, 32'sd5, 0, 0, 1, '{MINV, -32'sd5, ST_OK}},
      '{OP_CONJ, MAXV, MINV, 0, 0, 1, '{MAXV, MAXV, ST_SAT}},
      '{OP_NEG, MINV, MINV, 7, 7, 1, '{MAXV, MAXV, ST_SAT}},
      '{OP_NEG, MAXV, 32'sd0, 0, 0, 1, '{-MAXV, 32'sd0, ST_OK}},
      '{OP_MAG, 32'sh30000, 32'sh40000, 0, 0, 1, '{32'sh50000, 0, ST_OK}},
      '{OP_MAG, MINV, MINV, 0, 0, 0, '0},
      '{OP_MAG, 32'sd0, 32'sd0, 0, 0, 1, '{0, 0, ST_OK}},
      '{OP_ANGLE, 0, 0, MAXV, MAXV, 1, '{0, 0, ST_OK}},
      '{OP_ANGLE, -32'sh10000, 0, 0, 0, 0, '0},
      '{OP_ANGLE, MINV, 0, 0, 0, 0, '0},
      '{OP_ANGLE, -32'sd1, -32'sd1, 0, 0, 0, '0},
      '{OP_ANGLE, 32'sd0, MAXV, 0, 0, 0, '0},
      '{OP_ANGLE, MAXV, MINV, 0, 0, 0, '0}
    };

    // reset
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      rw = dir_tbl[i];
      send_item(rw.op, rw.ar, rw.ai, rw.br, rw.bi, rw.typed, rw.res);
    end

    for (k = 0; k < N_RANDOM; k++) begin
      // sender waits out every outstanding result once
      if (k == 500) begin
        in_valid_i = 1'b0;
        wait (result_q.size() == 0);
        @(negedge clk_i);
      end
      // long receiver hold-off while items keep coming
      if (k == 200 || k == 900) hold_req = 1'b1;
      op = op_e'($urandom_range(0, 7));
      ar = rand_operand();
      ai = rand_operand();
      br = rand_operand();
      bi = rand_operand();
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(op, ar, ai, br, bi, 1'b0, '0);
      if (k > 100 && !(k > 190 && k < 300)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: input_gap($urandom_range(1, 3));
          3:       input_gap($urandom_range(8, 30));
          default: ;
        endcase
      end
    end
    in_valid_i = 1'b0;

    // drain
    wait (result_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    done = 1'b1;

    $display("items %0d, results %0d; per opcode add..angle: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_in, n_out, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    $display("saturated results %0d, divide by zero %0d, mismatches %0d",
             n_sat, n_divz, n_fail);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/cau_pkg.sv
hdl/complex_arithmetic_unit.sv
verif/tb.sv
